FILE: hdl/dhcp_lease_pool_manager_macros.svh
// ----------------------------------------------------------------------------
// DHCP lease pool manager assertion macros
// Shared property wrappers for the port-level checker.
// ----------------------------------------------------------------------------
`ifndef DHCP_LEASE_POOL_MANAGER_MACROS_SVH
`define DHCP_LEASE_POOL_MANAGER_MACROS_SVH

// same-cycle implication
`define DLPM_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define DLPM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hdl/dlpm_pkg.sv
// ----------------------------------------------------------------------------
// dlpm_pkg
// Types, codes and reset values shared by the lease pool manager modules.
// ----------------------------------------------------------------------------
`default_nettype none

package dlpm_pkg;

    localparam int POOL_DEPTH_DEF = 256;
    localparam int CFG_IDX_W      = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_POOL_SIZE     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DEFAULT_LEASE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_LEASE     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_LEASE     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SERVER_ID     = 3'd4;

    localparam logic [8:0]  POOL_SIZE_RST     = 9'd256;
    localparam logic [31:0] DEFAULT_LEASE_RST = 32'd60;
    localparam logic [31:0] MAX_LEASE_RST     = 32'd3600;
    localparam logic [31:0] MIN_LEASE_RST     = 32'd30;
    localparam logic [15:0] SERVER_ID_RST     = 16'd0;

    localparam logic [1:0] CMD_DIS = 2'd0;
    localparam logic [1:0] CMD_REQ = 2'd1;

    localparam logic [1:0] ST_FREE     = 2'd0;
    localparam logic [1:0] ST_OFFERED  = 2'd1;
    localparam logic [1:0] ST_OCCUPIED = 2'd2;
    localparam logic [1:0] ST_EXPIRED  = 2'd3;

    localparam logic [1:0] KIND_OFFER = 2'd0;
    localparam logic [1:0] KIND_ACK   = 2'd1;
    localparam logic [1:0] KIND_NAK   = 2'd2;

    // token operations walking the cell chain
    localparam logic [1:0] OP_DIS       = 2'd0;
    localparam logic [1:0] OP_REQ_THIS  = 2'd1;
    localparam logic [1:0] OP_REQ_OTHER = 2'd2;
    localparam logic [1:0] OP_WRITE     = 2'd3;

    // discover pick ranking, higher wins
    localparam logic [1:0] CLS_NONE    = 2'd0;
    localparam logic [1:0] CLS_EXPIRED = 2'd1;
    localparam logic [1:0] CLS_FREE    = 2'd2;
    localparam logic [1:0] CLS_OWN     = 2'd3;

    typedef struct packed {
        logic [31:0] now;
        logic [15:0] client_id;
        logic        to_broadcast;
        logic [15:0] to_server;
        logic [1:0]  command;
        logic [15:0] asked_address;
        logic [31:0] asked_expiry;
    } t_in;

    typedef struct packed {
        logic [1:0]  reply_kind;
        logic [15:0] reply_client;
        logic [15:0] reply_address;
        logic [31:0] reply_lease_end;
    } t_out;

    typedef struct packed {
        logic [8:0]  pool_size;
        logic [31:0] default_lease;
        logic [31:0] max_lease;
        logic [31:0] min_lease;
        logic [15:0] server_id;
    } t_cfg;

    typedef struct packed {
        logic        valid;
        logic [1:0]  op;
        logic [31:0] key;
        logic [15:0] client;
        logic [15:0] addr;
        logic [1:0]  wst;
        logic [1:0]  cls;
        logic [15:0] hit;
    } t_tok;

endpackage

`default_nettype wire

FILE: hdl/dlpm_cell.sv
// ----------------------------------------------------------------------------
// dlpm_cell
// One pool entry: lapses, searches, frees or writes as a token passes by.
// ----------------------------------------------------------------------------
`default_nettype none

module dlpm_cell #(
    parameter int IDX = 0
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic [8:0]     i_pool_size,
    input  wire dlpm_pkg::t_tok i_tok,
    output dlpm_pkg::t_tok      o_tok
);

    localparam logic [15:0] ADDR = 16'(IDX + 1);

    logic [1:0]     r_st,  n_st;
    logic [15:0]    r_own, n_own;
    logic [31:0]    r_end, n_end;
    dlpm_pkg::t_tok r_tok, n_tok;

    logic        active;
    logic        lapse;
    logic [1:0]  st1;
    logic [15:0] own1;
    logic [31:0] end1;
    logic [1:0]  cand;
    logic        owned;

    always_comb begin
        active = ADDR <= {7'd0, i_pool_size};
        lapse  = (i_tok.op != dlpm_pkg::OP_WRITE) && active &&
                 (r_end != 32'd0) && (r_end <= i_tok.key);
        st1  = r_st;
        own1 = r_own;
        end1 = r_end;
        if (lapse) begin
            end1 = 32'd0;
            if (r_st == dlpm_pkg::ST_OFFERED) begin
                st1  = dlpm_pkg::ST_FREE;
                own1 = 16'd0;
            end else if (r_st == dlpm_pkg::ST_OCCUPIED) begin
                st1 = dlpm_pkg::ST_EXPIRED;
            end
        end
        owned = active && (st1 != dlpm_pkg::ST_FREE) && (own1 == i_tok.client);

        if (owned) begin
            cand = dlpm_pkg::CLS_OWN;
        end else if (active && st1 == dlpm_pkg::ST_FREE) begin
            cand = dlpm_pkg::CLS_FREE;
        end else if (active && st1 == dlpm_pkg::ST_EXPIRED) begin
            cand = dlpm_pkg::CLS_EXPIRED;
        end else begin
            cand = dlpm_pkg::CLS_NONE;
        end

        n_st  = r_st;
        n_own = r_own;
        n_end = r_end;
        n_tok = i_tok;
        if (i_tok.valid) begin
            case (i_tok.op)
                dlpm_pkg::OP_DIS: begin
                    n_st  = st1;
                    n_own = own1;
                    n_end = end1;
                    if (cand > i_tok.cls) begin
                        n_tok.cls = cand;
                        n_tok.hit = ADDR;
                    end
                end
                dlpm_pkg::OP_REQ_THIS: begin
                    n_st  = st1;
                    n_own = own1;
                    n_end = end1;
                    if (owned && i_tok.addr == ADDR) begin
                        n_tok.cls = dlpm_pkg::CLS_OWN;
                        n_tok.hit = ADDR;
                    end
                end
                dlpm_pkg::OP_REQ_OTHER: begin
                    n_st  = st1;
                    n_own = own1;
                    n_end = end1;
                    if (owned && st1 == dlpm_pkg::ST_OFFERED) begin
                        n_st  = dlpm_pkg::ST_FREE;
                        n_own = 16'd0;
                        n_end = 32'd0;
                    end
                end
                dlpm_pkg::OP_WRITE: begin
                    if (i_tok.addr == ADDR) begin
                        n_st  = i_tok.wst;
                        n_own = i_tok.client;
                        n_end = i_tok.key;
                    end
                end
                default: begin
                    n_st = r_st;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st  <= dlpm_pkg::ST_FREE;
            r_own <= 16'd0;
            r_end <= 32'd0;
            r_tok <= '0;
        end else begin
            r_st  <= n_st;
            r_own <= n_own;
            r_end <= n_end;
            r_tok <= n_tok;
        end
    end

    assign o_tok = r_tok;

endmodule

`default_nettype wire

FILE: hdl/dlpm_ctrl.sv
// ----------------------------------------------------------------------------
// dlpm_ctrl
// Message decode, lease arithmetic, token injection and reply register.
// ----------------------------------------------------------------------------
`default_nettype none

module dlpm_ctrl (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    output logic                o_in_ready,
    input  wire dlpm_pkg::t_in  i_in_data,
    output logic                o_out_valid,
    input  wire logic           i_out_ready,
    output dlpm_pkg::t_out      o_out_data,
    input  wire dlpm_pkg::t_cfg i_cfg,
    output dlpm_pkg::t_tok      o_tok,
    input  wire dlpm_pkg::t_tok i_tok
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_LEN1 = 3'd1;
    localparam logic [2:0] S_LEN2 = 3'd2;
    localparam logic [2:0] S_LEN3 = 3'd3;
    localparam logic [2:0] S_WAIT = 3'd4;

    logic [2:0]     r_state, n_state;
    dlpm_pkg::t_in  r_msg,   n_msg;
    logic [31:0]    r_d,     n_d;
    logic [31:0]    r_len,   n_len;
    logic [31:0]    r_end,   n_end;
    dlpm_pkg::t_tok r_res,   n_res;
    logic           r_res_v, n_res_v;
    dlpm_pkg::t_tok r_inj,   n_inj;
    logic           r_out_v, n_out_v;
    dlpm_pkg::t_out r_out,   n_out;

    logic        accept;
    logic        is_dis;
    logic        is_req;
    logic        found;
    logic        need_out;
    logic        do_wr;
    logic        out_free;
    logic [31:0] lo_len;
    logic [32:0] sum;

    always_comb begin
        accept   = i_in_valid && (r_state == S_IDLE);
        is_dis   = (i_in_data.command == dlpm_pkg::CMD_DIS) && i_in_data.to_broadcast;
        is_req   = (i_in_data.command == dlpm_pkg::CMD_REQ) && !i_in_data.to_broadcast;
        found    = r_res.cls != dlpm_pkg::CLS_NONE;
        need_out = (r_res.op == dlpm_pkg::OP_DIS && found) ||
                   (r_res.op == dlpm_pkg::OP_REQ_THIS);
        do_wr    = (r_res.op == dlpm_pkg::OP_DIS && found) ||
                   (r_res.op == dlpm_pkg::OP_REQ_THIS && r_res.cls == dlpm_pkg::CLS_OWN);
        out_free = !r_out_v || i_out_ready;
        lo_len   = (r_d > i_cfg.min_lease) ? r_d : i_cfg.min_lease;
        sum      = {1'b0, r_msg.now} + {1'b0, r_len};

        n_state = r_state;
        n_msg   = r_msg;
        n_d     = r_d;
        n_len   = r_len;
        n_end   = r_end;
        n_res   = r_res;
        n_res_v = r_res_v;
        n_out   = r_out;
        n_out_v = r_out_v && !i_out_ready;
        n_inj   = r_inj;
        n_inj.valid = 1'b0;

        // catch the scan token at the end of the chain
        if (i_tok.valid && i_tok.op != dlpm_pkg::OP_WRITE) begin
            n_res   = i_tok;
            n_res_v = 1'b1;
        end

        case (r_state)
            S_IDLE: begin
                if (accept && (is_dis || is_req)) begin
                    n_msg       = i_in_data;
                    n_res_v     = 1'b0;
                    n_inj.valid = 1'b1;
                    if (is_dis) begin
                        n_inj.op = dlpm_pkg::OP_DIS;
                    end else if (i_in_data.to_server == i_cfg.server_id) begin
                        n_inj.op = dlpm_pkg::OP_REQ_THIS;
                    end else begin
                        n_inj.op = dlpm_pkg::OP_REQ_OTHER;
                    end
                    n_inj.key    = i_in_data.now;
                    n_inj.client = i_in_data.client_id;
                    n_inj.addr   = i_in_data.asked_address;
                    n_inj.wst    = dlpm_pkg::ST_FREE;
                    n_inj.cls    = dlpm_pkg::CLS_NONE;
                    n_inj.hit    = 16'd0;
                    n_state      = S_LEN1;
                end
            end
            S_LEN1: begin
                n_d = (r_msg.asked_expiry > r_msg.now) ?
                      (r_msg.asked_expiry - r_msg.now) : 32'd0;
                n_state = S_LEN2;
            end
            S_LEN2: begin
                if (r_msg.asked_expiry == 32'd0) begin
                    n_len = i_cfg.default_lease;
                end else begin
                    n_len = (lo_len > i_cfg.max_lease) ? i_cfg.max_lease : lo_len;
                end
                n_state = S_LEN3;
            end
            S_LEN3: begin
                n_end   = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
                n_state = S_WAIT;
            end
            S_WAIT: begin
                if (r_res_v && (!need_out || out_free)) begin
                    n_state = S_IDLE;
                    if (need_out) begin
                        n_out_v            = 1'b1;
                        n_out.reply_client = r_msg.client_id;
                        if (r_res.op == dlpm_pkg::OP_DIS) begin
                            n_out.reply_kind    = dlpm_pkg::KIND_OFFER;
                            n_out.reply_address = r_res.hit;
                        end else if (do_wr) begin
                            n_out.reply_kind    = dlpm_pkg::KIND_ACK;
                            n_out.reply_address = r_msg.asked_address;
                        end else begin
                            n_out.reply_kind    = dlpm_pkg::KIND_NAK;
                            n_out.reply_address = r_msg.asked_address;
                        end
                        n_out.reply_lease_end = do_wr ? r_end : 32'd0;
                    end
                    if (do_wr) begin
                        n_inj.valid  = 1'b1;
                        n_inj.op     = dlpm_pkg::OP_WRITE;
                        n_inj.key    = r_end;
                        n_inj.client = r_msg.client_id;
                        n_inj.addr   = r_res.hit;
                        n_inj.wst    = (r_res.op == dlpm_pkg::OP_DIS) ?
                                       dlpm_pkg::ST_OFFERED : dlpm_pkg::ST_OCCUPIED;
                        n_inj.cls    = dlpm_pkg::CLS_NONE;
                        n_inj.hit    = 16'd0;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_msg <= n_msg;
        r_d   <= n_d;
        r_len <= n_len;
        r_end <= n_end;
        r_res <= n_res;
        r_out <= n_out;
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_res_v <= 1'b0;
            r_out_v <= 1'b0;
            r_inj   <= '0;
        end else begin
            r_state <= n_state;
            r_res_v <= n_res_v;
            r_out_v <= n_out_v;
            r_inj   <= n_inj;
        end
    end

    assign o_in_ready  = r_state == S_IDLE;
    assign o_out_valid = r_out_v;
    assign o_out_data  = r_out;
    assign o_tok       = r_inj;

endmodule

`default_nettype wire

FILE: hdl/dhcp_lease_pool_manager.sv
// Flow: a discover or a request is taken only while idle; the next message is
//   held off until its token has walked the chain of POOL_DEPTH entry cells,
//   one cell per cycle, and its reply, if any, has entered the output register.
//   A message that is ignored is taken and dropped while idle.
// Reset: synchronous; every entry is free with zero owner and end, and
//   configuration returns to its defaults.
// ----------------------------------------------------------------------------
// dhcp_lease_pool_manager
// Address pool server: configuration registers, controller and entry chain.
// ----------------------------------------------------------------------------
`default_nettype none

module dhcp_lease_pool_manager #(
    parameter int POOL_DEPTH = dlpm_pkg::POOL_DEPTH_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    output logic                               o_in_ready,
    input  wire dlpm_pkg::t_in                 i_in_data,
    output logic                               o_out_valid,
    input  wire logic                          i_out_ready,
    output dlpm_pkg::t_out                     o_out_data,
    input  wire logic                          i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire logic [dlpm_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [31:0]                   i_cfg_data
);

    dlpm_pkg::t_cfg r_cfg;
    dlpm_pkg::t_tok w_chain [0:POOL_DEPTH];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.pool_size     <= dlpm_pkg::POOL_SIZE_RST;
            r_cfg.default_lease <= dlpm_pkg::DEFAULT_LEASE_RST;
            r_cfg.max_lease     <= dlpm_pkg::MAX_LEASE_RST;
            r_cfg.min_lease     <= dlpm_pkg::MIN_LEASE_RST;
            r_cfg.server_id     <= dlpm_pkg::SERVER_ID_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                dlpm_pkg::CFG_POOL_SIZE:     r_cfg.pool_size     <= i_cfg_data[8:0];
                dlpm_pkg::CFG_DEFAULT_LEASE: r_cfg.default_lease <= i_cfg_data;
                dlpm_pkg::CFG_MAX_LEASE:     r_cfg.max_lease     <= i_cfg_data;
                dlpm_pkg::CFG_MIN_LEASE:     r_cfg.min_lease     <= i_cfg_data;
                dlpm_pkg::CFG_SERVER_ID:     r_cfg.server_id     <= i_cfg_data[15:0];
                default: begin
                    r_cfg <= r_cfg;
                end
            endcase
        end
    end

    assign o_cfg_ready = 1'b1;

    dlpm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg       (r_cfg),
        .o_tok       (w_chain[0]),
        .i_tok       (w_chain[POOL_DEPTH])
    );

    for (genvar g = 0; g < POOL_DEPTH; g++) begin : g_cell
        dlpm_cell #(
            .IDX (g)
        ) u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_pool_size (r_cfg.pool_size),
            .i_tok       (w_chain[g]),
            .o_tok       (w_chain[g+1])
        );
    end

endmodule

`default_nettype wire

FILE: hdl/dlpm_checker.sv
// ----------------------------------------------------------------------------
// dlpm_checker
// Port-level properties of the lease pool manager, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "dhcp_lease_pool_manager_macros.svh"

module dlpm_checker (
    input wire logic           i_clk,
    input wire logic           i_rst_n,
    input wire logic           i_in_valid,
    input wire logic           o_in_ready,
    input wire dlpm_pkg::t_in  i_in_data,
    input wire logic           o_out_valid,
    input wire logic           i_out_ready,
    input wire dlpm_pkg::t_out o_out_data
);

    `DLPM_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid && $stable(o_out_data), "stalled reply beat changed")

    `DLPM_ASSERT_NOW(a_nak_zero, i_clk, i_rst_n, o_out_valid && (o_out_data.reply_kind == dlpm_pkg::KIND_NAK), o_out_data.reply_lease_end == 32'd0, "nak with nonzero lease end")

    `DLPM_ASSERT_NOW(a_grant_addr, i_clk, i_rst_n, o_out_valid && (o_out_data.reply_kind != dlpm_pkg::KIND_NAK), o_out_data.reply_address != 16'd0, "offer or ack of address zero")

    `DLPM_ASSERT_NEXT(a_busy, i_clk, i_rst_n, i_in_valid && o_in_ready && (((i_in_data.command == dlpm_pkg::CMD_DIS) && i_in_data.to_broadcast) || ((i_in_data.command == dlpm_pkg::CMD_REQ) && !i_in_data.to_broadcast)), !o_in_ready, "pool message did not hold off the next beat")

endmodule

bind dhcp_lease_pool_manager dlpm_checker u_dlpm_checker (.*);

`default_nettype wire

FILE: verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the lease pool manager. A directed table of
// messages and register writes runs first, then randomized phases with
// varied pool sizes, lease limits, server ids and handshake idling. Each
// reply beat is compared with a typed table reply or an untimed pool predictor.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import dlpm_pkg::*;

    localparam int DEPTH       = POOL_DEPTH_DEF;
    localparam int DRAIN       = DEPTH + 8;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int PHASES      = 8;
    localparam int PHASE_ITEMS = 52;

    localparam logic [1:0] CMD_IGN_A = 2'd2;
    localparam logic [1:0] CMD_IGN_B = 2'd3;

    typedef enum logic {ROW_MSG, ROW_CFG} t_row_kind;

    typedef struct {
        t_row_kind             kind;
        t_in                   msg;
        bit                    typed;
        t_out                  reply;
        logic [CFG_IDX_W-1:0]  idx;
        logic [31:0]           data;
    } t_dir_row;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_in_valid = 1'b0;
    logic                 o_in_ready;
    t_in                  i_in_data = '0;
    logic                 o_out_valid;
    logic                 i_out_ready = 1'b0;
    t_out                 o_out_data;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [31:0]          i_cfg_data = '0;

    logic [1:0]  pool_st  [DEPTH];
    logic [15:0] pool_own [DEPTH];
    logic [31:0] pool_end [DEPTH];
    logic [8:0]  cfg_pool    = POOL_SIZE_RST;
    logic [31:0] cfg_default = DEFAULT_LEASE_RST;
    logic [31:0] cfg_max     = MAX_LEASE_RST;
    logic [31:0] cfg_min     = MIN_LEASE_RST;
    logic [15:0] cfg_srv     = SERVER_ID_RST;

    t_out        pending_replies [$];
    t_dir_row    dir_rows [$];
    logic [15:0] clients [6];
    logic [31:0] cur_now = '0;
    int          snd_idle = 0;
    int          rcv_stall = 0;
    int          mismatches = 0;
    int          cycle_cnt = 0;

    dhcp_lease_pool_manager dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        i_out_ready <= ($urandom_range(0, 99) >= rcv_stall);
    end

    function automatic t_in mk_in(input logic [31:0] now, input logic [15:0] client,
                                  input logic bc, input logic [15:0] srv,
                                  input logic [1:0] cmd, input logic [15:0] addr,
                                  input logic [31:0] expiry);
        t_in m;
        m.now           = now;
        m.client_id     = client;
        m.to_broadcast  = bc;
        m.to_server     = srv;
        m.command       = cmd;
        m.asked_address = addr;
        m.asked_expiry  = expiry;
        return m;
    endfunction

    function automatic t_out mk_out(input logic [1:0] kind, input logic [15:0] client,
                                    input logic [15:0] addr, input logic [31:0] lease_end);
        t_out r;
        r.reply_kind      = kind;
        r.reply_client    = client;
        r.reply_address   = addr;
        r.reply_lease_end = lease_end;
        return r;
    endfunction

    function automatic void add_msg(input t_in m);
        t_dir_row row;
        row.kind  = ROW_MSG;
        row.msg   = m;
        row.typed = 1'b0;
        row.reply = '0;
        row.idx   = '0;
        row.data  = '0;
        dir_rows.push_back(row);
    endfunction

    function automatic void add_typed(input t_in m, input t_out r);
        t_dir_row row;
        row.kind  = ROW_MSG;
        row.msg   = m;
        row.typed = 1'b1;
        row.reply = r;
        row.idx   = '0;
        row.data  = '0;
        dir_rows.push_back(row);
    endfunction

    function automatic void add_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
        t_dir_row row;
        row.kind  = ROW_CFG;
        row.msg   = '0;
        row.typed = 1'b0;
        row.reply = '0;
        row.idx   = idx;
        row.data  = data;
        dir_rows.push_back(row);
    endfunction

    function automatic logic [31:0] advance(input logic [31:0] t, input logic [31:0] step);
        logic [32:0] sum;
        sum = {1'b0, t} + {1'b0, step};
        return sum[32] ? 32'hFFFF_FFFF : sum[31:0];
    endfunction

    function automatic int unsigned active_size();
        return (cfg_pool > DEPTH) ? DEPTH : int'(cfg_pool);
    endfunction

    function automatic logic [31:0] lease_end_at(input logic [31:0] now,
                                                 input logic [31:0] asked);
        logic [31:0] len;
        logic [31:0] d;
        if (asked == '0) begin
            len = cfg_default;
        end else begin
            d   = (asked > now) ? asked - now : '0;
            len = (d > cfg_min) ? d : cfg_min;
            if (len > cfg_max) len = cfg_max;
        end
        return advance(now, len);
    endfunction

    function automatic bit serve_msg(input t_in m, output t_out r);
        int unsigned size;
        int unsigned pick;
        int unsigned i;
        size = active_size();
        r    = '0;
        if (m.command == CMD_DIS && !m.to_broadcast) return 1'b0;
        if (m.command != CMD_DIS && (m.command != CMD_REQ || m.to_broadcast)) return 1'b0;
        for (i = 0; i < size; i++) begin
            if (pool_end[i] != '0 && pool_end[i] <= m.now) begin
                if (pool_st[i] == ST_OFFERED) begin
                    pool_st[i]  = ST_FREE;
                    pool_own[i] = '0;
                end else if (pool_st[i] == ST_OCCUPIED) begin
                    pool_st[i] = ST_EXPIRED;
                end
                pool_end[i] = '0;
            end
        end
        if (m.command == CMD_DIS) begin
            pick = 0;
            for (i = 0; i < size && pick == 0; i++)
                if (pool_st[i] != ST_FREE && pool_own[i] == m.client_id) pick = i + 1;
            for (i = 0; i < size && pick == 0; i++)
                if (pool_st[i] == ST_FREE) pick = i + 1;
            for (i = 0; i < size && pick == 0; i++)
                if (pool_st[i] == ST_EXPIRED) pick = i + 1;
            if (pick == 0) return 1'b0;
            pool_st[pick-1]  = ST_OFFERED;
            pool_own[pick-1] = m.client_id;
            pool_end[pick-1] = lease_end_at(m.now, m.asked_expiry);
            r = mk_out(KIND_OFFER, m.client_id, pick[15:0], pool_end[pick-1]);
            return 1'b1;
        end
        if (m.to_server != cfg_srv) begin
            for (i = 0; i < size; i++) begin
                if (pool_st[i] == ST_OFFERED && pool_own[i] == m.client_id) begin
                    pool_st[i]  = ST_FREE;
                    pool_own[i] = '0;
                    pool_end[i] = '0;
                end
            end
            return 1'b0;
        end
        if (m.asked_address < 1 || m.asked_address > size ||
            pool_st[m.asked_address-1] == ST_FREE ||
            pool_own[m.asked_address-1] != m.client_id) begin
            r = mk_out(KIND_NAK, m.client_id, m.asked_address, '0);
            return 1'b1;
        end
        pool_st[m.asked_address-1]  = ST_OCCUPIED;
        pool_end[m.asked_address-1] = lease_end_at(m.now, m.asked_expiry);
        r = mk_out(KIND_ACK, m.client_id, m.asked_address, pool_end[m.asked_address-1]);
        return 1'b1;
    endfunction

    function automatic logic [31:0] rand_expiry(input logic [31:0] now);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 35) return '0;
        if (r < 75) return now + $urandom_range(0, 4000);
        if (r < 88) return $urandom;
        return now - $urandom_range(0, 50);
    endfunction

    function automatic t_in rand_msg();
        t_in         m;
        int unsigned roll;
        int unsigned size;
        int unsigned i;
        int unsigned owned;
        roll = $urandom_range(0, 99);
        size = active_size();
        cur_now = advance(cur_now, ($urandom_range(0, 99) < 80) ? $urandom_range(0, 20)
                                                                 : $urandom_range(0, 2000));
        m = mk_in(cur_now, clients[$urandom_range(0, 5)], 1'b0, 16'($urandom), CMD_REQ,
                  16'($urandom), rand_expiry(cur_now));
        if (roll < 35) begin
            m.command      = CMD_DIS;
            m.to_broadcast = 1'b1;
        end else if (roll < 70) begin
            m.to_server = cfg_srv;
            owned = 0;
            for (i = 0; i < size && owned == 0; i++)
                if (pool_st[i] != ST_FREE && pool_own[i] == m.client_id) owned = i + 1;
            if (owned != 0 && $urandom_range(0, 99) < 70)
                m.asked_address = owned[15:0];
            else
                m.asked_address = 16'($urandom_range(0, size + 2));
        end else if (roll < 80) begin
            m.to_server = cfg_srv + 16'(1 + $urandom_range(0, 65534));
        end else begin
            m.command      = 2'($urandom_range(0, 3));
            m.to_broadcast = 1'($urandom_range(0, 1));
        end
        return m;
    endfunction

    task automatic send_msg(input t_in m, input bit typed, input t_out typed_reply);
        t_out r;
        bit   has;
        while ($urandom_range(0, 99) < snd_idle) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= m;
        do @(posedge i_clk); while (!o_in_ready);
        has = serve_msg(m, r);
        if (typed) pending_replies.push_back(typed_reply);
        else if (has) pending_replies.push_back(r);
    endtask

    task automatic quiesce();
        i_in_valid <= 1'b0;
        while (pending_replies.size() != 0) @(posedge i_clk);
        repeat (DRAIN) @(posedge i_clk);
    endtask

    task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_POOL_SIZE:     cfg_pool    = data[8:0];
            CFG_DEFAULT_LEASE: cfg_default = data;
            CFG_MAX_LEASE:     cfg_max     = data;
            CFG_MIN_LEASE:     cfg_min     = data;
            CFG_SERVER_ID:     cfg_srv     = data[15:0];
            default: ;
        endcase
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic flag_mismatch(input string what, input t_out exp_r, input t_out got_r);
        mismatches++;
        if (mismatches <= 10)
            $display("%s: exp %0d/%h/%h/%h got %0d/%h/%h/%h",
                     what, exp_r.reply_kind, exp_r.reply_client, exp_r.reply_address,
                     exp_r.reply_lease_end, got_r.reply_kind, got_r.reply_client,
                     got_r.reply_address, got_r.reply_lease_end);
    endtask

    always @(posedge i_clk) begin
        t_out want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_replies.size() == 0) begin
                flag_mismatch("reply beat with nothing pending", '0, o_out_data);
            end else begin
                want = pending_replies.pop_front();
                if (o_out_data.reply_kind !== want.reply_kind ||
                    o_out_data.reply_client !== want.reply_client ||
                    o_out_data.reply_address !== want.reply_address ||
                    o_out_data.reply_lease_end !== want.reply_lease_end)
                    flag_mismatch("reply mismatch", want, o_out_data);
            end
        end
    end

    initial begin
        t_dir_row    row;
        t_in         m;
        int          ph;
        int          k;
        int          counted;
        int unsigned pool_pick [PHASES];
        logic [31:0] dl;
        logic [31:0] mn;
        logic [31:0] mx;
        logic [15:0] srv;

        pool_pick = '{3, 1, 8, 511, 2, 256, 5, 0};
        for (k = 0; k < DEPTH; k++) begin
            pool_st[k]  = ST_FREE;
            pool_own[k] = '0;
            pool_end[k] = '0;
        end

        add_typed(mk_in(0, 16'd1, 1'b1, 16'd0, CMD_DIS, 16'd0, 0),
                  mk_out(KIND_OFFER, 16'd1, 16'd1, 32'd60));
        add_typed(mk_in(0, 16'd1, 1'b0, 16'd0, CMD_REQ, 16'd1, 0),
                  mk_out(KIND_ACK, 16'd1, 16'd1, 32'd60));
        add_cfg(CFG_DEFAULT_LEASE, 32'd0);
        add_typed(mk_in(0, 16'd2, 1'b1, 16'd0, CMD_DIS, 16'd0, 0),
                  mk_out(KIND_OFFER, 16'd2, 16'd2, 32'd0));
        add_cfg(CFG_DEFAULT_LEASE, 32'd60);
        add_typed(mk_in(5, 16'hFFFF, 1'b0, 16'd0, CMD_REQ, 16'd0, 0),
                  mk_out(KIND_NAK, 16'hFFFF, 16'd0, 32'd0));
        add_typed(mk_in(5, 16'hFFFF, 1'b0, 16'd0, CMD_REQ, 16'hFFFF, 32'hFFFF_FFFF),
                  mk_out(KIND_NAK, 16'hFFFF, 16'hFFFF, 32'd0));
        add_typed(mk_in(5, 16'd3, 1'b0, 16'd0, CMD_REQ, 16'd3, 0),
                  mk_out(KIND_NAK, 16'd3, 16'd3, 32'd0));
        add_typed(mk_in(5, 16'd3, 1'b0, 16'd0, CMD_REQ, 16'd1, 0),
                  mk_out(KIND_NAK, 16'd3, 16'd1, 32'd0));
        add_msg(mk_in(6, 16'd1, 1'b1, 16'hFFFF, CMD_IGN_A, 16'hFFFF, 32'hFFFF_FFFF));
        add_msg(mk_in(6, 16'd1, 1'b0, 16'd0, CMD_IGN_B, 16'd1, 0));
        add_msg(mk_in(6, 16'd4, 1'b0, 16'd0, CMD_DIS, 16'd0, 0));
        add_msg(mk_in(6, 16'd1, 1'b1, 16'd0, CMD_REQ, 16'd1, 0));
        add_msg(mk_in(7, 16'd1, 1'b1, 16'd0, CMD_DIS, 16'd0, 32'd107));
        add_msg(mk_in(8, 16'd5, 1'b1, 16'd0, CMD_DIS, 16'd0, 32'd3));
        add_msg(mk_in(9, 16'd5, 1'b0, 16'd7, CMD_REQ, 16'd3, 0));
        add_msg(mk_in(200, 16'd6, 1'b1, 16'd0, CMD_DIS, 16'd0, 32'hFFFF_FFFF));
        add_cfg(CFG_POOL_SIZE, 32'd2);
        add_cfg(CFG_SERVER_ID, 32'h0000_FFFF);
        add_cfg(CFG_DEFAULT_LEASE, 32'hFFFF_FFFF);
        add_cfg(CFG_MIN_LEASE, 32'hFFFF_FFFF);
        add_cfg(CFG_MAX_LEASE, 32'hFFFF_FFFF);
        add_msg(mk_in(201, 16'd7, 1'b1, 16'd0, CMD_DIS, 16'd0, 0));
        add_msg(mk_in(201, 16'd6, 1'b0, 16'hFFFF, CMD_REQ, 16'd1, 0));
        add_msg(mk_in(202, 16'd2, 1'b0, 16'hFFFF, CMD_REQ, 16'd2, 32'd500));
        add_cfg(CFG_MAX_LEASE, 32'd0);
        add_msg(mk_in(203, 16'd2, 1'b1, 16'd0, CMD_DIS, 16'd0, 32'd1000));
        add_cfg(CFG_POOL_SIZE, 32'd0);
        add_msg(mk_in(204, 16'd8, 1'b1, 16'd0, CMD_DIS, 16'd0, 0));
        add_typed(mk_in(204, 16'd6, 1'b0, 16'hFFFF, CMD_REQ, 16'd1, 0),
                  mk_out(KIND_NAK, 16'd6, 16'd1, 32'd0));
        add_cfg(CFG_POOL_SIZE, 32'd511);
        add_cfg(CFG_MAX_LEASE, 32'd3600);
        add_cfg(CFG_MIN_LEASE, 32'd30);
        add_cfg(CFG_DEFAULT_LEASE, 32'd60);
        add_cfg(CFG_SERVER_ID, 32'h0000_00A5);
        add_msg(mk_in(300, 16'd9, 1'b1, 16'd0, CMD_DIS, 16'd0, 0));
        add_msg(mk_in(300, 16'd9, 1'b0, 16'h00A5, CMD_REQ, 16'd2, 0));

        i_rst_n <= 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[k]) begin
            row = dir_rows[k];
            if (row.kind == ROW_CFG) begin
                quiesce();
                write_cfg(row.idx, row.data);
            end else begin
                send_msg(row.msg, row.typed, row.reply);
            end
        end
        cur_now = 300;

        for (ph = 0; ph < PHASES; ph++) begin
            quiesce();
            case (ph % 4)
                0: begin snd_idle = 0;  rcv_stall = 0;  end
                1: begin snd_idle = 58; rcv_stall = 0;  end
                2: begin snd_idle = 0;  rcv_stall = 58; end
                default: begin snd_idle = 31; rcv_stall = 31; end
            endcase
            dl  = (ph == 1) ? 32'hFFFF_FFFF : (ph == 4) ? 32'd0 : $urandom_range(1, 200);
            mn  = (ph == 1) ? 32'd0 : (ph == 5) ? 32'hFFFF_FFFF : $urandom_range(0, 60);
            mx  = (ph == 1) ? 32'hFFFF_FFFF : (ph == 4) ? 32'd0 : $urandom_range(60, 3000);
            srv = (ph == 2) ? 16'hFFFF : (ph == 3) ? 16'h0000 : 16'($urandom);
            write_cfg(CFG_POOL_SIZE, (ph == PHASES - 1) ? $urandom_range(1, 511)
                                                         : pool_pick[ph]);
            write_cfg(CFG_DEFAULT_LEASE, dl);
            write_cfg(CFG_MAX_LEASE, mx);
            write_cfg(CFG_MIN_LEASE, mn);
            write_cfg(CFG_SERVER_ID, {16'd0, srv});
            for (k = 0; k < 6; k++) begin
                case ($urandom_range(0, 9))
                    0:       clients[k] = 16'h0000;
                    1:       clients[k] = 16'hFFFF;
                    default: clients[k] = 16'($urandom);
                endcase
            end
            if (ph == PHASES - 1)
                cur_now = advance(32'hFFFF_F000, $urandom_range(0, 255));
            else
                cur_now = advance(cur_now, $urandom_range(0, 1 << (3 * ph + 4)));
            counted = 0;
            while (counted < PHASE_ITEMS) begin
                m = rand_msg();
                if ((m.command == CMD_DIS && m.to_broadcast) ||
                    (m.command == CMD_REQ && !m.to_broadcast))
                    counted++;
                send_msg(m, 1'b0, '0);
            end
        end

        quiesce();
        if (mismatches == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire
